// ----- rtl/core/gtpu_pkg.sv -----
// package: types, codes and result decode for the gif tag packet unpacker
package gtpu_pkg;

  // list and queue sizing
  localparam int MAX_LIST_ENTRIES = 16;
  localparam int LIST_IDX_W = (MAX_LIST_ENTRIES > 1) ? $clog2(MAX_LIST_ENTRIES) : 1;
  localparam int LIST_LEN_W = $clog2(MAX_LIST_ENTRIES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LOOP_W = 15;

  // result kinds
  localparam logic [1:0] KIND_REG    = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_IMAGE  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // tag format codes
  localparam logic [1:0] FLG_PACKED    = 2'd0;
  localparam logic [1:0] FLG_REGLIST   = 2'd1;
  localparam logic [1:0] FLG_IMAGE     = 2'd2;
  localparam logic [1:0] FLG_IMAGE_ALT = 2'd3;

  // packed register descriptors
  localparam logic [3:0] DESC_PRIM  = 4'd0;
  localparam logic [3:0] DESC_RGBAQ = 4'd1;
  localparam logic [3:0] DESC_STQ   = 4'd2;
  localparam logic [3:0] DESC_UV    = 4'd3;
  localparam logic [3:0] DESC_XYZF2 = 4'd4;
  localparam logic [3:0] DESC_XYZ2  = 4'd5;
  localparam logic [3:0] DESC_AD    = 4'd14;
  localparam logic [3:0] DESC_NOP   = 4'd15;

  // register addresses
  localparam logic [7:0] REG_PRIM  = 8'h00;
  localparam logic [7:0] REG_RGBAQ = 8'h01;
  localparam logic [7:0] REG_ST    = 8'h02;
  localparam logic [7:0] REG_UV    = 8'h03;
  localparam logic [7:0] REG_XYZF2 = 8'h04;
  localparam logic [7:0] REG_XYZ2  = 8'h05;
  localparam logic [7:0] REG_FOG   = 8'h0A;
  localparam logic [7:0] REG_XYZF3 = 8'h0C;
  localparam logic [7:0] REG_XYZ3  = 8'h0D;
  localparam logic [7:0] REG_HWREG = 8'h54;

  localparam logic [63:0] FOG_MASK = 64'hff00_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PACKED = 2'd1,
    MODE_IMAGE  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_TAG    = 2'd0,
    OP_PACKED = 2'd1,
    OP_IMAGE  = 2'd2
  } op_e;

  typedef struct packed {
    logic [63:0] qword_hi;
    logic [63:0] qword_lo;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_addr;
    logic [63:0] payload;
    logic [1:0]  half_mask;
    logic        kick;
    logic        last;
  } out_t;

  // one classified quadword waiting for the back end
  typedef struct packed {
    op_e         op;
    logic [3:0]  desc;
    logic        pre;
    logic [1:0]  cnt;
    logic [63:0] lo;
    logic [63:0] hi;
  } cmd_t;

  // number of results for a packed descriptor
  function automatic logic [1:0] gtpu_count(logic [3:0] desc, logic [7:0] dest);
    logic [1:0] n;
    n = 2'd1;
    case (desc) inside
      DESC_PRIM, DESC_RGBAQ, DESC_UV: n = 2'd1;
      DESC_STQ, DESC_XYZ2:            n = 2'd2;
      DESC_XYZF2:                     n = 2'd3;
      DESC_AD: begin
        if (dest == REG_XYZF2 || dest == REG_XYZF3) begin
          n = 2'd3;
        end else if (dest == REG_XYZ2 || dest == REG_XYZ3 || dest == REG_HWREG) begin
          n = 2'd2;
        end else begin
          n = 2'd1;
        end
      end
      DESC_NOP: n = 2'd0;
      default: begin
        n = (desc == REG_XYZF3[3:0] || desc == REG_XYZ3[3:0]) ? 2'd2 : 2'd1;
      end
    endcase
    return n;
  endfunction

  // build one result item
  function automatic out_t gtpu_mk(logic [1:0] kind, logic [7:0] addr, logic [63:0] data,
                                   logic [1:0] mask, logic kick);
    out_t r;
    r.kind      = kind;
    r.reg_addr  = addr;
    r.payload   = data;
    r.half_mask = mask;
    r.kick      = kick;
    r.last      = 1'b0;
    return r;
  endfunction

  // result number step of a classified quadword
  function automatic out_t gtpu_result(cmd_t c, logic [1:0] step);
    out_t        r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] w_rgba;
    logic [63:0] w_uv;
    logic [63:0] w_xyzf;
    logic [63:0] w_xyz;
    logic [7:0]  dest;
    logic        kick;
    lo     = c.lo;
    hi     = c.hi;
    w_rgba = {32'b0, hi[39:32], hi[7:0], lo[39:32], lo[7:0]};
    w_uv   = {34'b0, lo[45:32], 2'b0, lo[13:0]};
    w_xyzf = {8'b0, hi[25:2], lo[47:32], lo[15:0]};
    w_xyz  = {hi[31:0], lo[47:32], lo[15:0]};
    dest   = hi[7:0];
    kick   = ~hi[47];
    r      = gtpu_mk(KIND_ERROR, 8'h00, 64'b0, 2'd0, 1'b0);
    case (c.op)
      OP_TAG: begin
        if (c.pre && step == 2'd0) begin
          r = gtpu_mk(KIND_REG, REG_PRIM, {53'b0, lo[57:47]}, 2'd3, 1'b0);
        end
      end
      OP_IMAGE: begin
        r = gtpu_mk(KIND_IMAGE, 8'h00, (step == 2'd0) ? lo : hi, 2'd0, 1'b0);
      end
      default: begin
        case (c.desc)
          DESC_PRIM:  r = gtpu_mk(KIND_REG, REG_PRIM, {53'b0, lo[10:0]}, 2'd3, 1'b0);
          DESC_RGBAQ: r = gtpu_mk(KIND_REG, REG_RGBAQ, w_rgba, 2'd1, 1'b0);
          DESC_STQ: begin
            if (step == 2'd0) r = gtpu_mk(KIND_REG, REG_ST, lo, 2'd3, 1'b0);
            else r = gtpu_mk(KIND_REG, REG_RGBAQ, {hi[31:0], 32'b0}, 2'd2, 1'b0);
          end
          DESC_UV: r = gtpu_mk(KIND_REG, REG_UV, w_uv, 2'd3, 1'b0);
          DESC_XYZF2: begin
            if (step == 2'd0) r = gtpu_mk(KIND_REG, REG_FOG, {hi[43:36], 56'b0}, 2'd3, 1'b0);
            else if (step == 2'd1) r = gtpu_mk(KIND_REG, REG_XYZF2, w_xyzf, 2'd3, 1'b0);
            else r = gtpu_mk(KIND_VERTEX, 8'h00, w_xyzf, 2'd0, kick);
          end
          DESC_XYZ2: begin
            if (step == 2'd0) r = gtpu_mk(KIND_REG, REG_XYZ2, w_xyz, 2'd3, 1'b0);
            else r = gtpu_mk(KIND_VERTEX, 8'h00, w_xyz, 2'd0, kick);
          end
          DESC_AD: begin
            if (step == 2'd0) begin
              r = gtpu_mk(KIND_REG, dest, lo, 2'd3, 1'b0);
            end else if (dest == REG_XYZF2 || dest == REG_XYZF3) begin
              // a+d xyzf: fog write, then vertex of bits 55..0
              if (step == 2'd1) r = gtpu_mk(KIND_REG, REG_FOG, lo & FOG_MASK, 2'd3, 1'b0);
              else r = gtpu_mk(KIND_VERTEX, 8'h00, lo & ~FOG_MASK, 2'd0,
                               dest == REG_XYZF2);
            end else if (dest == REG_XYZ2 || dest == REG_XYZ3) begin
              r = gtpu_mk(KIND_VERTEX, 8'h00, lo, 2'd0, dest == REG_XYZ2);
            end else begin
              r = gtpu_mk(KIND_IMAGE, 8'h00, lo, 2'd0, 1'b0);
            end
          end
          default: begin
            if (step == 2'd0) r = gtpu_mk(KIND_REG, {4'b0, c.desc}, lo, 2'd3, 1'b0);
            else r = gtpu_mk(KIND_VERTEX, 8'h00, lo, 2'd0, 1'b0);
          end
        endcase
      end
    endcase
    r.last = (step == c.cnt - 2'd1);
    return r;
  endfunction

endpackage

// ----- rtl/core/gtpu_front.sv -----
// front end: tag decode, packed/image mode tracking and quadword classification
module gtpu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gtpu_pkg::in_t   in_data_i,
  input  logic            q_full_i,
  output logic            push_o,
  output gtpu_pkg::cmd_t  push_data_o
);

  gtpu_pkg::mode_e                    mode_q, mode_d;
  logic [gtpu_pkg::LOOP_W-1:0]        loops_q, loops_d;
  logic [gtpu_pkg::LIST_IDX_W-1:0]    idx_q, idx_d;
  logic [gtpu_pkg::LIST_LEN_W-1:0]    len_q, len_d;
  logic [63:0]                        list_q, list_d;

  logic                               accept;
  logic [63:0]                        lo;
  logic [63:0]                        hi;
  logic [gtpu_pkg::LOOP_W-1:0]        nloop;
  logic [gtpu_pkg::LOOP_W-1:0]        loops_dec;
  logic [1:0]                         flg;
  logic                               image_fmt;
  logic                               pre;
  logic                               err;
  logic [4:0]                         nregs;
  logic [gtpu_pkg::LIST_LEN_W-1:0]    idx_inc;
  gtpu_pkg::cmd_t                     cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign lo         = in_data_i.qword_lo;
  assign hi         = in_data_i.qword_hi;
  assign nloop      = lo[gtpu_pkg::LOOP_W-1:0];
  assign loops_dec  = loops_q - gtpu_pkg::LOOP_W'(1);
  assign flg        = lo[59:58];
  assign image_fmt  = (flg == gtpu_pkg::FLG_IMAGE) || (flg == gtpu_pkg::FLG_IMAGE_ALT);
  assign pre        = ~image_fmt & lo[46];
  assign err        = (nloop != '0) && (flg == gtpu_pkg::FLG_REGLIST);
  assign idx_inc    = gtpu_pkg::LIST_LEN_W'(idx_q) + gtpu_pkg::LIST_LEN_W'(1);

  // register count: zero or oversized means the full list
  always_comb begin
    nregs = {1'b0, lo[63:60]};
    if (nregs == 5'd0 || nregs > 5'(gtpu_pkg::MAX_LIST_ENTRIES)) begin
      nregs = 5'(gtpu_pkg::MAX_LIST_ENTRIES);
    end
  end

  // mode state machine and classification
  always_comb begin
    mode_d   = mode_q;
    loops_d  = loops_q;
    idx_d    = idx_q;
    len_d    = len_q;
    list_d   = list_q;
    cmd      = '0;
    cmd.lo   = lo;
    cmd.hi   = hi;
    unique case (mode_q)
      gtpu_pkg::MODE_PACKED: begin
        cmd.op   = gtpu_pkg::OP_PACKED;
        cmd.desc = list_q[4*idx_q +: 4];
        cmd.cnt  = gtpu_pkg::gtpu_count(cmd.desc, hi[7:0]);
        if (accept) begin
          idx_d = gtpu_pkg::LIST_IDX_W'(idx_inc);
          if (idx_inc >= len_q) begin
            idx_d   = '0;
            loops_d = loops_dec;
            if (loops_dec == '0) begin
              mode_d = gtpu_pkg::MODE_IDLE;
            end
          end
        end
      end
      gtpu_pkg::MODE_IMAGE: begin
        cmd.op  = gtpu_pkg::OP_IMAGE;
        cmd.cnt = 2'd2;
        if (accept) begin
          loops_d = loops_dec;
          if (loops_dec == '0) begin
            mode_d = gtpu_pkg::MODE_IDLE;
          end
        end
      end
      gtpu_pkg::MODE_IDLE: begin
        cmd.op  = gtpu_pkg::OP_TAG;
        cmd.pre = pre;
        cmd.cnt = {1'b0, pre} + {1'b0, err};
        if (accept && nloop != '0) begin
          if (flg == gtpu_pkg::FLG_PACKED) begin
            mode_d  = gtpu_pkg::MODE_PACKED;
            loops_d = nloop;
            idx_d   = '0;
            len_d   = gtpu_pkg::LIST_LEN_W'(nregs);
            list_d  = hi;
          end else if (image_fmt) begin
            mode_d  = gtpu_pkg::MODE_IMAGE;
            loops_d = nloop;
          end
        end
      end
      default: begin
        mode_d = gtpu_pkg::MODE_IDLE;
      end
    endcase
  end

  assign push_o      = accept && (cmd.cnt != 2'd0);
  assign push_data_o = cmd;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= gtpu_pkg::MODE_IDLE;
      loops_q <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      list_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      loops_q <= loops_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      list_q  <= list_d;
    end
  end

endmodule

// ----- rtl/core/gtpu_queue.sv -----
// short command queue between front and back end
module gtpu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gtpu_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output gtpu_pkg::cmd_t  head_data_o
);

  gtpu_pkg::cmd_t                    mem_q [gtpu_pkg::QUEUE_DEPTH];
  logic [gtpu_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
  logic [gtpu_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
  logic [gtpu_pkg::QUEUE_CNT_W-1:0]  cnt_q;

  localparam logic [gtpu_pkg::QUEUE_PTR_W-1:0] PtrLast =
    gtpu_pkg::QUEUE_PTR_W'(gtpu_pkg::QUEUE_DEPTH - 1);

  assign full_o       = (cnt_q == gtpu_pkg::QUEUE_CNT_W'(gtpu_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + gtpu_pkg::QUEUE_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + gtpu_pkg::QUEUE_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + gtpu_pkg::QUEUE_CNT_W'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - gtpu_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/gtpu_back.sv -----
// back end: steps through the results of each command into the output register
module gtpu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  gtpu_pkg::cmd_t  head_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gtpu_pkg::out_t  out_data_o
);

  logic [1:0]      step_q;
  logic            out_valid_q;
  gtpu_pkg::out_t  out_q;
  gtpu_pkg::out_t  res;
  logic            load;

  assign res         = gtpu_pkg::gtpu_result(head_data_i, step_q);
  assign load        = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load && res.last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  // step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= res.last ? 2'd0 : step_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/gif_tag_packet_unpacker.sv -----
// top level: gif tag packet unpacker, front end, command queue and back end
// a quadword's command is written to the queue, then its first result to the output register
// throughput: while out_stall_i is low, one quadword per cycle when each gives at most
//   one result; otherwise one result per cycle, and a quadword gives up to 3 results
// the result port and its single output register set that rate; a queue of two
//   commands lets the front keep taking quadwords while results drain
// reset clears the mode (idle, awaiting a tag), the queue and the output valid

module gif_tag_packet_unpacker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gtpu_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output gtpu_pkg::out_t  out_data_o
);

  logic            q_full;
  logic            push;
  gtpu_pkg::cmd_t  push_data;
  logic            pop;
  logic            head_valid;
  gtpu_pkg::cmd_t  head_data;

  // tag decode and classification
  gtpu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  gtpu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  // result sequencing
  gtpu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // a reglist error is always the final result of its tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == gtpu_pkg::KIND_ERROR |-> out_data_o.last)
    else $error("reglist error not marked last");

  // register writes carry a half mask, other kinds none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.kind == gtpu_pkg::KIND_REG) == (out_data_o.half_mask != 2'd0)))
    else $error("half mask does not match result kind");

  // the queue never takes a command while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("push into full command queue");

  // the back end only pops a command it holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid && !(out_valid_o && out_stall_i))
    else $error("pop without transfer into output register");

endmodule
